>>> design/kpl_pkg.sv
// shared types, codes and reset constants of the keypad passcode lock
package kpl_pkg;

  // default entry length in digits
  localparam int CODE_LEN_DEF = 4;

  // field widths
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int DIGITS_W   = 3;
  localparam int PASS_W     = 4;
  localparam int ATT_W      = 2;
  localparam int LOCK_W     = 6;
  localparam int IDLE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // reset values of the configuration registers
  localparam logic [PASS_W-1:0] PASSCODE_RST      = 4'd10;
  localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST  = 2'd3;
  localparam logic [LOCK_W-1:0] LOCKOUT_TICKS_RST = 6'd60;
  localparam logic [IDLE_W-1:0] IDLE_TICKS_RST    = 3'd5;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // reported status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING  = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_WRONG    = 3'd3,
    ST_BLOCKED  = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASSCODE      = 2'd0,
    CFG_MAX_ATTEMPTS  = 2'd1,
    CFG_LOCKOUT_TICKS = 2'd2,
    CFG_IDLE_TICKS    = 2'd3
  } cfg_idx_t;

  // one result transaction
  typedef struct packed {
    status_t             status;
    logic [DIGITS_W-1:0] digits_entered;
    logic [ATT_W-1:0]    attempts_left;
    logic [LOCK_W-1:0]   lock_remaining;
  } result_t;

endpackage

>>> design/kpl_core.sv
// lock state, configuration registers and per-transaction update logic
module kpl_core
  import kpl_pkg::*;
#(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [CMD_W-1:0]      cmd,
  input  logic                  key_id,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               res
);

  localparam int CW = $clog2(CODE_LEN + 1);
  localparam int PW = (CODE_LEN > PASS_W) ? CODE_LEN : PASS_W;

  // configuration registers
  logic [PASS_W-1:0] passcode;
  logic [ATT_W-1:0]  max_attempts;
  logic [LOCK_W-1:0] lockout_ticks;
  logic [IDLE_W-1:0] idle_ticks;

  // lock state
  logic [CODE_LEN-1:0] entry_digits, entry_digits_next;
  logic [CW-1:0]       digit_count, digit_count_next;
  logic [ATT_W-1:0]    attempts_remaining, attempts_remaining_next;
  logic [IDLE_W-1:0]   idle_count, idle_count_next;
  logic [LOCK_W-1:0]   lock_count, lock_count_next;

  logic [PW-1:0]       pass_wide;
  logic [CODE_LEN-1:0] pass_code;
  logic                full_cur, accepted_cur;
  status_t             status_cur, status_out;
  logic [CODE_LEN-1:0] entry_set;
  logic [CW:0]         count_inc;
  cmd_t                cmd_c;

  assign cmd_c     = cmd_t'(cmd);
  // passcode digits beyond the stored four count as key zero
  assign pass_wide = PW'(passcode);
  assign pass_code = pass_wide[CODE_LEN-1:0];

  // status of the held state
  assign full_cur     = (digit_count >= CW'(CODE_LEN));
  assign accepted_cur = full_cur && (entry_digits == pass_code);

  always_comb begin
    if (lock_count != '0) begin
      status_cur = ST_BLOCKED;
    end else if (accepted_cur) begin
      status_cur = ST_ACCEPTED;
    end else if (idle_count == '0) begin
      status_cur = ST_TIMEOUT;
    end else begin
      status_cur = ST_PENDING;
    end
  end

  // entry with the pressed key appended at the current digit position
  always_comb begin
    entry_set = entry_digits;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (key_id && (digit_count == CW'(i))) begin
        entry_set[i] = 1'b1;
      end
    end
  end

  assign count_inc = {1'b0, digit_count} + 1'b1;

  // next state and reported status
  always_comb begin
    entry_digits_next       = entry_digits;
    digit_count_next        = digit_count;
    attempts_remaining_next = attempts_remaining;
    idle_count_next         = idle_count;
    lock_count_next         = lock_count;
    status_out              = status_cur;
    case (cmd_c)
      CMD_START: begin
        entry_digits_next       = '0;
        digit_count_next        = '0;
        attempts_remaining_next = max_attempts;
        idle_count_next         = idle_ticks;
        if (lock_count != '0) begin
          status_out = ST_BLOCKED;
        end else if (idle_ticks == '0) begin
          status_out = ST_TIMEOUT;
        end else begin
          status_out = ST_PENDING;
        end
      end
      CMD_KEY: begin
        if (status_cur == ST_PENDING) begin
          idle_count_next = idle_ticks;
          if (count_inc >= (CW+1)'(CODE_LEN)) begin
            if (entry_set == pass_code) begin
              entry_digits_next = entry_set;
              digit_count_next  = CW'(count_inc);
              status_out        = ST_ACCEPTED;
            end else begin
              entry_digits_next = '0;
              digit_count_next  = '0;
              if (attempts_remaining <= ATT_W'(1)) begin
                attempts_remaining_next = '0;
                lock_count_next         = lockout_ticks;
                // a zero-length lockout ends at once
                if (lockout_ticks == '0) begin
                  attempts_remaining_next = max_attempts;
                end
                status_out = ST_BLOCKED;
              end else begin
                attempts_remaining_next = attempts_remaining - 1'b1;
                status_out              = ST_WRONG;
              end
            end
          end else begin
            entry_digits_next = entry_set;
            digit_count_next  = CW'(count_inc);
          end
        end
      end
      CMD_TICK: begin
        if (lock_count != '0) begin
          lock_count_next = lock_count - 1'b1;
          if (lock_count == LOCK_W'(1)) begin
            // lockout over: restore attempts and reopen the entry
            attempts_remaining_next = max_attempts;
            entry_digits_next       = '0;
            digit_count_next        = '0;
            idle_count_next         = idle_ticks;
            status_out = (idle_ticks == '0) ? ST_TIMEOUT : ST_PENDING;
          end else begin
            status_out = ST_BLOCKED;
          end
        end else if (!accepted_cur && (idle_count != '0)) begin
          idle_count_next = idle_count - 1'b1;
          status_out = (idle_count == IDLE_W'(1)) ? ST_TIMEOUT : ST_PENDING;
        end
      end
      default: begin
        status_out = status_cur;
      end
    endcase
  end

  // result fields follow the updated state
  always_comb begin
    res.status         = status_out;
    res.digits_entered = DIGITS_W'(digit_count_next);
    res.attempts_left  = attempts_remaining_next;
    res.lock_remaining = lock_count_next;
  end

  // state update, one transaction per cycle while take is high
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_digits       <= '0;
      digit_count        <= '0;
      attempts_remaining <= MAX_ATTEMPTS_RST;
      idle_count         <= IDLE_TICKS_RST;
      lock_count         <= '0;
    end else if (take) begin
      entry_digits       <= entry_digits_next;
      digit_count        <= digit_count_next;
      attempts_remaining <= attempts_remaining_next;
      idle_count         <= idle_count_next;
      lock_count         <= lock_count_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      passcode      <= PASSCODE_RST;
      max_attempts  <= MAX_ATTEMPTS_RST;
      lockout_ticks <= LOCKOUT_TICKS_RST;
      idle_ticks    <= IDLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PASSCODE:      passcode      <= cfg_data[PASS_W-1:0];
        CFG_MAX_ATTEMPTS:  max_attempts  <= cfg_data[ATT_W-1:0];
        CFG_LOCKOUT_TICKS: lockout_ticks <= cfg_data[LOCK_W-1:0];
        CFG_IDLE_TICKS:    idle_ticks    <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // digit count never passes the entry length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CW'(CODE_LEN))
    else $error("digit count beyond entry length");

  // the last lockout tick clears the entry and restores attempts
  a_lock_end: assert property (@(posedge clk) disable iff (rst)
    (take && (cmd_c == CMD_TICK) && (lock_count == LOCK_W'(1))) |=>
      (lock_count == '0) && (digit_count == '0) &&
      (attempts_remaining == $past(max_attempts)))
    else $error("lockout end did not restore the session");

  // an accepted result leaves a full entry behind
  a_accept_full: assert property (@(posedge clk) disable iff (rst)
    (take && (res.status == ST_ACCEPTED)) |=> (digit_count == CW'(CODE_LEN)))
    else $error("accepted without a full entry");
`endif

endmodule

>>> design/kpl_out_buf.sv
// result register with one skid entry
module kpl_out_buf
  import kpl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  // the skid entry holding data stops the input side
  assign full = skid_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTHESIS
  // skid entry is only used behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry filled with empty result register");

  // the skid entry fills only while the result register is stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid entry filled without a stall");

  // a drained skid entry moves into the result register
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> out_valid)
    else $error("skid entry lost");
`endif

endmodule

>>> design/keypad_passcode_lock.sv
// keypad passcode lock: two-key passcode entry with retry limit, lockout and idle timeout
//
// Input channel (in_valid / in_stall) carries one command per transaction: start a
// session, a key press with key_id, or one elapsed tick. Every input transaction yields
// exactly one result transaction on the output channel (out_valid / out_stall) with the
// status, digits entered, attempts left and lockout ticks remaining.
// The result of a taken transaction goes into the result register, or into the skid entry
// while that register stalls. Throughput is one transaction per cycle while in_stall is low.
// A result register plus one skid entry sit on the output; when the receiver stalls, one
// more transaction is absorbed and then in_stall rises until the skid entry drains.
// The configuration channel (cfg_valid / cfg_ready) writes passcode, max attempts,
// lockout length and idle timeout by index; cfg_ready is always high. Writes belong
// to quiet periods with no transaction in flight.
// Synchronous reset empties the output side, restores default configuration and puts
// the lock in a fresh state: no digits, full attempts, idle counter loaded, no lockout.
module keypad_passcode_lock
  import kpl_pkg::*;
#(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic                  key_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [DIGITS_W-1:0]   digits_entered,
  output logic [ATT_W-1:0]      attempts_left,
  output logic [LOCK_W-1:0]     lock_remaining,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    take;
  logic    buf_full;
  result_t res;
  result_t out_res;

  // handshakes
  assign in_stall  = buf_full;
  assign take      = in_valid && !buf_full;
  assign cfg_ready = 1'b1;

  // lock state and update logic
  kpl_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cmd       (cmd),
    .key_id    (key_id),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // result register and skid entry
  kpl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // result fields to ports
  assign status         = out_res.status;
  assign digits_entered = out_res.digits_entered;
  assign attempts_left  = out_res.attempts_left;
  assign lock_remaining = out_res.lock_remaining;

endmodule

>>> dv/kpl_lock_checker.sv
// checker for the passcode lock: predicts each result from accepted commands and compares
`timescale 1ns / 100ps
module kpl_lock_checker
  import kpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic                  key_id,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STATUS_W-1:0]   status,
  input  logic [DIGITS_W-1:0]   digits_entered,
  input  logic [ATT_W-1:0]      attempts_left,
  input  logic [LOCK_W-1:0]     lock_remaining,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    results_pending
);

  // settings as last written
  logic [PASS_W-1:0] code_cfg;
  logic [ATT_W-1:0]  tries_cfg;
  logic [LOCK_W-1:0] lock_len_cfg;
  logic [IDLE_W-1:0] idle_len_cfg;

  // lock state as the design should hold it
  logic [PASS_W-1:0]   entry;
  logic [DIGITS_W-1:0] digits;
  logic [ATT_W-1:0]    tries_left;
  logic [IDLE_W-1:0]   idle_left;
  logic [LOCK_W-1:0]   lock_left;

  result_t expected_results[$];

  function automatic bit entry_unlocks();
    return (digits >= CODE_LEN_DEF) && (entry == code_cfg);
  endfunction

  // status priority: lockout, then a full matching entry, then timeout
  function automatic status_t lock_status();
    if (lock_left != '0) return ST_BLOCKED;
    if (entry_unlocks()) return ST_ACCEPTED;
    if (idle_left == '0) return ST_TIMEOUT;
    return ST_PENDING;
  endfunction

  function automatic void reopen_after_lockout();
    tries_left = tries_cfg;
    entry = '0;
    digits = '0;
    idle_left = idle_len_cfg;
  endfunction

  // advance the lock by one command and return the result it reports
  function automatic result_t predict_lock_step(logic [CMD_W-1:0] c, logic k);
    result_t r;
    status_t st;
    case (c)
      CMD_START: begin
        entry = '0;
        digits = '0;
        tries_left = tries_cfg;
        idle_left = idle_len_cfg;
        st = lock_status();
      end
      CMD_KEY: begin
        st = lock_status();
        // keys only count while an entry is open
        if (st == ST_PENDING) begin
          if (k) entry = entry | (PASS_W'(1) << digits);
          digits = digits + 1'b1;
          idle_left = idle_len_cfg;
          if (digits >= CODE_LEN_DEF) begin
            if (entry_unlocks()) begin
              st = ST_ACCEPTED;
            end else begin
              entry = '0;
              digits = '0;
              if (tries_left <= 1) begin
                tries_left = '0;
                lock_left = lock_len_cfg;
                if (lock_left == '0) reopen_after_lockout();
                st = ST_BLOCKED;
              end else begin
                tries_left = tries_left - 1'b1;
                st = ST_WRONG;
              end
            end
          end
        end
      end
      CMD_TICK: begin
        // lockout counts first; idle counter stops once accepted
        if (lock_left != '0) begin
          lock_left = lock_left - 1'b1;
          if (lock_left == '0) reopen_after_lockout();
        end else if (!entry_unlocks() && idle_left != '0) begin
          idle_left = idle_left - 1'b1;
        end
        st = lock_status();
      end
      default: st = lock_status();
    endcase
    r.status = st;
    r.digits_entered = digits;
    r.attempts_left = tries_left;
    r.lock_remaining = lock_left;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (got === want) return 1'b1;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1'b0;
  endfunction

  // track configuration, input and output transactions
  always @(posedge clk) begin : track
    result_t want;
    bit ok;
    if (rst) begin
      code_cfg = PASSCODE_RST;
      tries_cfg = MAX_ATTEMPTS_RST;
      lock_len_cfg = LOCKOUT_TICKS_RST;
      idle_len_cfg = IDLE_TICKS_RST;
      entry = '0;
      digits = '0;
      tries_left = MAX_ATTEMPTS_RST;
      idle_left = IDLE_TICKS_RST;
      lock_left = '0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // result side first: a result never belongs to a command taken at the same edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no command waiting: status %0d", status);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          ok = field_ok("status", 8'(want.status), 8'(status));
          ok = field_ok("digits_entered", 8'(want.digits_entered), 8'(digits_entered)) && ok;
          ok = field_ok("attempts_left", 8'(want.attempts_left), 8'(attempts_left)) && ok;
          ok = field_ok("lock_remaining", 8'(want.lock_remaining), 8'(lock_remaining)) && ok;
          if (!ok) mismatch_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PASSCODE:      code_cfg = cfg_data[PASS_W-1:0];
          CFG_MAX_ATTEMPTS:  tries_cfg = cfg_data[ATT_W-1:0];
          CFG_LOCKOUT_TICKS: lock_len_cfg = cfg_data[LOCK_W-1:0];
          CFG_IDLE_TICKS:    idle_len_cfg = cfg_data[IDLE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_lock_step(cmd, key_id));
    end
    results_pending <= expected_results.size();
  end

endmodule

>>> dv/keypad_passcode_lock_tb.sv
// testbench top for the passcode lock: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module keypad_passcode_lock_tb
  import kpl_pkg::*;
();

  // command value the lock does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd = '0;
  logic                  key_id = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [DIGITS_W-1:0]   digits_entered;
  logic [ATT_W-1:0]      attempts_left;
  logic [LOCK_W-1:0]     lock_remaining;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatch_count;
  int                    results_pending;

  // settings in force, used to shape entries and tick runs
  logic [PASS_W-1:0] code_now = PASSCODE_RST;
  logic [LOCK_W-1:0] lock_now = LOCKOUT_TICKS_RST;
  logic [IDLE_W-1:0] idle_now = IDLE_TICKS_RST;

  int items_sent = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  keypad_passcode_lock DUT (.*);

  kpl_lock_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // one command transaction, in bursts with random gaps unless steady
  task automatic send_item(input logic [CMD_W-1:0] c, input logic k);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    key_id <= k;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold off until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // new settings once the lock is quiet; unused upper data bits are random
  task automatic configure(input logic [PASS_W-1:0] code, input logic [ATT_W-1:0] tries,
                           input logic [LOCK_W-1:0] lock_len,
                           input logic [IDLE_W-1:0] idle_len);
    logic [CFG_DATA_W-1:0] noise;
    drain();
    noise = CFG_DATA_W'($urandom());
    write_reg(CFG_PASSCODE, {noise[CFG_DATA_W-1:PASS_W], code});
    noise = CFG_DATA_W'($urandom());
    write_reg(CFG_MAX_ATTEMPTS, {noise[CFG_DATA_W-1:ATT_W], tries});
    write_reg(CFG_LOCKOUT_TICKS, lock_len);
    noise = CFG_DATA_W'($urandom());
    write_reg(CFG_IDLE_TICKS, {noise[CFG_DATA_W-1:IDLE_W], idle_len});
    cfg_valid <= 1'b0;
    code_now = code;
    lock_now = lock_len;
    idle_now = idle_len;
  endtask

  // sessions: start, a few entries (often the right code), then a run of ticks
  task automatic run_sessions(input int quota, input int tick_pct);
    int stop_at;
    int tail;
    logic [PASS_W-1:0] guess;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 6) begin
        send_item(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 9) != 0) send_item(CMD_START, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) begin
          guess = ($urandom_range(0, 99) < 45) ? code_now : PASS_W'($urandom());
          for (int d = 0; d < PASS_W; d++) begin
            if ($urandom_range(0, 99) < tick_pct)
              send_item(CMD_TICK, 1'($urandom_range(0, 1)));
            send_item(CMD_KEY, guess[d]);
            // broken entry now and then
            if ($urandom_range(0, 99) < 5) break;
          end
        end
        if ($urandom_range(0, 1) != 0) tail = int'($urandom_range(0, lock_now + idle_now + 2));
        else tail = int'($urandom_range(0, 3));
        repeat (tail) send_item(CMD_TICK, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) < 4) drain();
      end
    end
  endtask

  // result side: stall segments of varying density, one long hold when asked
  initial begin : receiver
    int seg_len;
    int stall_pct;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
      end
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (seg_len) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // acceptance, keys after it, lockout with a start inside, timeout
    configure(4'hA, 2'd1, 6'd2, 3'd1);
    send_item(CMD_UNUSED, 1'b1);
    send_item(CMD_START, 1'b0);
    send_item(CMD_KEY, 1'b0);
    send_item(CMD_KEY, 1'b1);
    send_item(CMD_KEY, 1'b0);
    send_item(CMD_KEY, 1'b1);
    send_item(CMD_KEY, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_START, 1'b1);
    repeat (4) send_item(CMD_KEY, 1'b1);
    send_item(CMD_KEY, 1'b0);
    send_item(CMD_START, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_KEY, 1'b1);

    // no attempts and no lockout length: wrong entry blocks and reopens at once
    configure(4'h0, 2'd0, 6'd0, 3'd7);
    send_item(CMD_START, 1'b0);
    repeat (4) send_item(CMD_KEY, 1'b1);

    // zero idle length: a session times out as it opens
    configure(4'hF, 2'd3, 6'd5, 3'd0);
    send_item(CMD_START, 1'b1);
    send_item(CMD_KEY, 1'b0);

    // random sessions over a spread of settings
    configure(4'hF, 2'd3, 6'd63, 3'd7);
    run_sessions(200, 10);
    configure(4'h0, 2'd1, 6'd1, 3'd1);
    run_sessions(200, 20);
    configure(4'h0, 2'd0, 6'd0, 3'd0);
    run_sessions(60, 20);
    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 3) == 0)
        configure(PASS_W'($urandom()), ATT_W'($urandom()),
                  LOCK_W'($urandom_range(0, 63)), IDLE_W'($urandom()));
      else
        configure(PASS_W'($urandom()), ATT_W'($urandom()),
                  LOCK_W'($urandom_range(0, 6)), IDLE_W'($urandom()));
      steady = (p == 0) || ($urandom_range(0, 3) == 0);
      // long receiver hold while commands keep coming
      if (p == 0) hold_req <= 1'b1;
      run_sessions(200, $urandom_range(0, 40));
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
design/kpl_pkg.sv
design/kpl_core.sv
design/kpl_out_buf.sv
design/keypad_passcode_lock.sv
dv/kpl_lock_checker.sv
dv/keypad_passcode_lock_tb.sv
